@@ hdl/icfd_pkg.sv @@
// icfd_pkg: shared types, codes and helpers of the instruction class and field decoder
// no dependencies; used by every stage module and by the top level

package icfd_pkg;

   // instruction classes as reported on the result channel
   typedef enum logic [2:0] {
      CLASS_BRANCH    = 3'd0,
      CLASS_MULTIPLY  = 3'd1,
      CLASS_SWI       = 3'd2,
      CLASS_DATA_PROC = 3'd3,
      CLASS_SINGLE    = 3'd4,
      CLASS_BLOCK     = 3'd5,
      CLASS_UNKNOWN   = 3'd6
   } class_type;

   // second operand forms
   typedef enum logic [1:0] {
      FORM_PLAIN     = 2'd0,
      FORM_IMM_SHIFT = 2'd1,
      FORM_REG_SHIFT = 2'd2,
      FORM_IMMEDIATE = 2'd3
   } form_type;

   // major opcode groups, bits 27..25
   localparam logic [2:0] GRP_DP_REG     = 3'd0;
   localparam logic [2:0] GRP_DP_IMM     = 3'd1;
   localparam logic [2:0] GRP_SINGLE_IMM = 3'd2;
   localparam logic [2:0] GRP_SINGLE_REG = 3'd3;
   localparam logic [2:0] GRP_BLOCK      = 3'd4;
   localparam logic [2:0] GRP_BRANCH     = 3'd5;

   localparam logic [31:0] MUL_MASK   = 32'h0fc000f0;
   localparam logic [31:0] MUL_MATCH  = 32'h00000090;
   localparam logic [31:0] SWI_MASK   = 32'h0f000000;
   localparam logic [31:0] SHIFT_MASK = 32'h00000ff0;

   // compare group tst/teq/cmp/cmn: opcode bits 3..2
   localparam logic [1:0]  OPC_COMPARE_GRP = 2'b10;
   localparam logic [3:0]  REG_PC          = 4'hf;
   localparam logic [31:0] PIPE_OFFSET     = 32'd8;

   // stage 1 -> stage 2
   typedef struct packed {
      logic [31:0] addr;
      logic [31:0] word;
      class_type   iclass;
      logic [3:0]  pop_lo;
      logic [3:0]  pop_hi;
   } s1_type;

   // stage 2 -> stage 3
   typedef struct packed {
      class_type   iclass;
      logic [3:0]  cond;
      logic [3:0]  operation;
      logic [3:0]  modifier;
      logic [3:0]  dest;
      logic [3:0]  base;
      logic [3:0]  second;
      logic [3:0]  shift_reg;
      form_type    form;
      logic [1:0]  stype;
      logic [31:0] target;
      logic [31:0] imm_rot;
      logic [4:0]  shamt;
      logic [4:0]  count;
      logic [23:0] low_word;
   } s2_type;

   // result transaction fields
   typedef struct packed {
      class_type   iclass;
      logic [3:0]  cond;
      logic [3:0]  operation;
      logic [3:0]  modifier;
      logic [3:0]  dest;
      logic [3:0]  base;
      logic [3:0]  second;
      logic [3:0]  shift_reg;
      form_type    form;
      logic [1:0]  stype;
      logic [31:0] value;
      logic [4:0]  count;
   } rsp_type;

   function automatic logic [3:0] popcount8(input logic [7:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'd0, v[i]};
      end
      return n;
   endfunction

endpackage

@@ hdl/icfd_classify.sv @@
// icfd_classify: stage 1, sorts the instruction word into its class and counts list halves
// depends on icfd_pkg

module icfd_classify (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  logic [31:0]         addr,
   input  logic [31:0]         word,
   output logic                dn_valid,
   input  logic                dn_ready,
   output icfd_pkg::s1_type    dn_data
);

   logic             valid_ff, valid_in;
   icfd_pkg::s1_type data_ff, data_in;
   logic [2:0]       grp;

   assign up_ready = !valid_ff || dn_ready;
   assign grp      = word[27:25];

   always_comb begin
      data_in.addr   = addr;
      data_in.word   = word;
      data_in.pop_lo = icfd_pkg::popcount8(word[7:0]);
      data_in.pop_hi = icfd_pkg::popcount8(word[15:8]);
      // priority: branch, multiply, swi, data processing, single, block
      if (grp == icfd_pkg::GRP_BRANCH) begin
         data_in.iclass = icfd_pkg::CLASS_BRANCH;
      end else if ((word & icfd_pkg::MUL_MASK) == icfd_pkg::MUL_MATCH) begin
         data_in.iclass = icfd_pkg::CLASS_MULTIPLY;
      end else if ((word & icfd_pkg::SWI_MASK) == icfd_pkg::SWI_MASK) begin
         data_in.iclass = icfd_pkg::CLASS_SWI;
      end else if (grp == icfd_pkg::GRP_DP_REG || grp == icfd_pkg::GRP_DP_IMM) begin
         data_in.iclass = icfd_pkg::CLASS_DATA_PROC;
      end else if (grp == icfd_pkg::GRP_SINGLE_IMM || grp == icfd_pkg::GRP_SINGLE_REG) begin
         data_in.iclass = icfd_pkg::CLASS_SINGLE;
      end else if (grp == icfd_pkg::GRP_BLOCK) begin
         data_in.iclass = icfd_pkg::CLASS_BLOCK;
      end else begin
         data_in.iclass = icfd_pkg::CLASS_UNKNOWN;
      end
   end

   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

@@ hdl/icfd_extract.sv @@
// icfd_extract: stage 2, pulls the per-class fields and computes target, immediate and count
// depends on icfd_pkg

module icfd_extract (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  icfd_pkg::s1_type    up_data,
   output logic                dn_valid,
   input  logic                dn_ready,
   output icfd_pkg::s2_type    dn_data
);

   logic             valid_ff, valid_in;
   icfd_pkg::s2_type data_ff, data_in;
   logic [31:0]      w;
   logic [63:0]      rot_wide;
   logic [31:0]      off_ext;

   assign up_ready = !valid_ff || dn_ready;
   assign w        = up_data.word;

   // rotate right by twice bits 11..8
   assign rot_wide = {24'd0, w[7:0], 24'd0, w[7:0]} >> {w[11:8], 1'b0};
   assign off_ext  = {{6{w[23]}}, w[23:0], 2'b00};

   always_comb begin
      data_in           = '0;
      data_in.iclass    = up_data.iclass;
      data_in.cond      = w[31:28];
      data_in.target    = up_data.addr + icfd_pkg::PIPE_OFFSET + off_ext;
      data_in.imm_rot   = rot_wide[31:0];
      data_in.shamt     = w[11:7];
      data_in.count     = {1'b0, up_data.pop_lo} + {1'b0, up_data.pop_hi};
      data_in.low_word  = w[23:0];
      data_in.form      = icfd_pkg::FORM_PLAIN;
      unique case (up_data.iclass)
         icfd_pkg::CLASS_BRANCH: begin
            data_in.operation = {3'd0, w[24]};
         end
         icfd_pkg::CLASS_MULTIPLY: begin
            data_in.operation = {3'd0, w[21]};
            data_in.modifier  = {3'd0, w[20]};
            data_in.dest      = w[19:16];
            data_in.base      = w[15:12];
            data_in.second    = w[3:0];
            data_in.shift_reg = w[11:8];
         end
         icfd_pkg::CLASS_DATA_PROC: begin
            data_in.operation = w[24:21];
            data_in.modifier  = {(w[24:23] == icfd_pkg::OPC_COMPARE_GRP)
                                 && (w[15:12] == icfd_pkg::REG_PC), 2'b00, w[20]};
            data_in.dest      = w[15:12];
            data_in.base      = w[19:16];
         end
         icfd_pkg::CLASS_SINGLE: begin
            data_in.operation = {3'd0, w[20]};
            data_in.modifier  = {1'b0, w[21], w[22], 1'b0};
            data_in.dest      = w[15:12];
            data_in.base      = w[19:16];
         end
         icfd_pkg::CLASS_BLOCK: begin
            data_in.operation = {1'b0, w[20], w[24:23]};
            data_in.modifier  = {w[22], w[21], 2'b00};
            data_in.base      = w[19:16];
         end
         default: begin
         end
      endcase

      // register operand: immediate group bit 25 set for dp, clear for single
      if ((up_data.iclass == icfd_pkg::CLASS_DATA_PROC && w[25]) ) begin
         data_in.form = icfd_pkg::FORM_IMMEDIATE;
      end else if ((up_data.iclass == icfd_pkg::CLASS_DATA_PROC && !w[25])
                   || (up_data.iclass == icfd_pkg::CLASS_SINGLE && w[25])) begin
         data_in.second = w[3:0];
         if ((w & icfd_pkg::SHIFT_MASK) != '0) begin
            data_in.stype = w[6:5];
            if (w[4]) begin
               data_in.form      = icfd_pkg::FORM_REG_SHIFT;
               data_in.shift_reg = w[11:8];
            end else begin
               data_in.form = icfd_pkg::FORM_IMM_SHIFT;
            end
         end
      end
   end

   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

@@ hdl/icfd_format.sv @@
// icfd_format: stage 3, selects the value field and holds the result output register
// depends on icfd_pkg

module icfd_format (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  icfd_pkg::s2_type    up_data,
   output logic                dn_valid,
   input  logic                dn_ready,
   output icfd_pkg::rsp_type   dn_data
);

   logic              valid_ff, valid_in;
   icfd_pkg::rsp_type data_ff, data_in;

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      data_in.iclass    = up_data.iclass;
      data_in.cond      = up_data.cond;
      data_in.operation = up_data.operation;
      data_in.modifier  = up_data.modifier;
      data_in.dest      = up_data.dest;
      data_in.base      = up_data.base;
      data_in.second    = up_data.second;
      data_in.shift_reg = up_data.shift_reg;
      data_in.form      = up_data.form;
      data_in.stype     = up_data.stype;
      data_in.value     = '0;
      data_in.count     = '0;
      unique case (up_data.iclass)
         icfd_pkg::CLASS_BRANCH: begin
            data_in.value = up_data.target;
         end
         icfd_pkg::CLASS_SWI: begin
            data_in.value = {8'd0, up_data.low_word};
         end
         icfd_pkg::CLASS_DATA_PROC, icfd_pkg::CLASS_SINGLE: begin
            if (up_data.form == icfd_pkg::FORM_IMMEDIATE) begin
               data_in.value = up_data.imm_rot;
            end else if (up_data.form == icfd_pkg::FORM_IMM_SHIFT) begin
               data_in.value = {27'd0, up_data.shamt};
            end
         end
         icfd_pkg::CLASS_BLOCK: begin
            data_in.value = {16'd0, up_data.low_word[15:0]};
            data_in.count = up_data.count;
         end
         default: begin
         end
      endcase
   end

   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

@@ hdl/instruction_class_field_decoder.sv @@
// instruction_class_field_decoder: top level, three-stage instruction class and field decoder
// depends on icfd_pkg, icfd_classify, icfd_extract, icfd_format
// an accepted req transaction passes the classify, extract and format registers before it leaves
// throughput: one transaction per cycle while rsp is ready, three stages and no shared unit
// each stage holds its word under rsp backpressure and still accepts when it empties
// reset: synchronous, active high, clears every stage valid bit; payload registers keep data

module instruction_class_field_decoder (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // fetch_address[31:0], instruction_word[63:32]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata     // instr_class[2:0], cond_code[6:3], operation[10:7],
                                     // modifier_flags[14:11], reg_dest[18:15],
                                     // reg_base[22:19], reg_second[26:23], reg_shift[30:27],
                                     // operand_form[32:31], shift_type[34:33],
                                     // value_out[66:35], register_count[71:67]
);

   // stage handshakes
   logic              s1_valid, s1_ready;
   logic              s2_valid, s2_ready;
   icfd_pkg::s1_type  s1_data;
   icfd_pkg::s2_type  s2_data;
   icfd_pkg::rsp_type rsp;

   // stage 1: class decode and register list half counts
   icfd_classify u_classify (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .addr     (req_tdata[31:0]),
      .word     (req_tdata[63:32]),
      .dn_valid (s1_valid),
      .dn_ready (s1_ready),
      .dn_data  (s1_data)
   );

   // stage 2: field extraction, branch target add, immediate rotate
   icfd_extract u_extract (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s1_valid),
      .up_ready (s1_ready),
      .up_data  (s1_data),
      .dn_valid (s2_valid),
      .dn_ready (s2_ready),
      .dn_data  (s2_data)
   );

   // stage 3: value selection into the output register
   icfd_format u_format (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s2_valid),
      .up_ready (s2_ready),
      .up_data  (s2_data),
      .dn_valid (rsp_tvalid),
      .dn_ready (rsp_tready),
      .dn_data  (rsp)
   );

   // pack result fields, class in the lowest bits, count in the highest
   assign rsp_tdata = {rsp.count, rsp.value, rsp.stype, rsp.form, rsp.shift_reg,
                       rsp.second, rsp.base, rsp.dest, rsp.modifier, rsp.operation,
                       rsp.cond, rsp.iclass};

   // unknown words carry only the condition field
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp.iclass == icfd_pkg::CLASS_UNKNOWN) |->
      (rsp_tdata[71:7] == '0))
   else $error("unknown class with nonzero fields");

   // a register count appears only on block transfers and never exceeds sixteen
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp.iclass == icfd_pkg::CLASS_BLOCK) ? (rsp.count <= 5'd16)
                                                            : (rsp.count == '0)))
   else $error("register count outside block transfer");

   // the immediate operand form belongs to data processing only
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp.form == icfd_pkg::FORM_IMMEDIATE) |->
      (rsp.iclass == icfd_pkg::CLASS_DATA_PROC))
   else $error("immediate form outside data processing");

   // a stalled middle stage keeps its transaction
   assert property (@(posedge clock) disable iff (reset)
      (s2_valid && !s2_ready) |=> (s2_valid && $stable(s2_data)))
   else $error("stage 2 transaction lost under stall");

endmodule

@@ tb/sv/instruction_class_field_decoder_tb.sv @@
// instruction_class_field_decoder_tb: self-checking bench for the instruction class and field decoder
// depends on icfd_pkg and instruction_class_field_decoder; directed words first, then random
// words shaped per instruction class, checked against a decode model held in the bench

module instruction_class_field_decoder_tb;

   localparam int RANDOM_WORDS = 1000;
   localparam int CYCLE_LIMIT  = 100000;  // watchdog limit on a hung handshake
   localparam int TAIL_CYCLES  = 12;      // pipeline is 3 deep, leave room for stragglers
   localparam int HOLD_START   = 250;     // accepted transactions before the long rsp stall
   localparam int HOLD_CYCLES  = 300;
   localparam int STEADY_FROM  = 500;     // window with no idling on either side
   localparam int STEADY_TO    = 800;
   localparam int REPORT_MAX   = 10;

   // expected fields of one result transaction
   typedef struct packed {
      icfd_pkg::class_type iclass;
      logic [3:0]          cond;
      logic [3:0]          operation;
      logic [3:0]          modifier;
      logic [3:0]          dest;
      logic [3:0]          base;
      logic [3:0]          second;
      logic [3:0]          shreg;
      icfd_pkg::form_type  form;
      logic [1:0]          stype;
      logic [31:0]         value;
      logic [4:0]          count;
   } decode_fields_type;

   // kinds of random word; most are well formed for one class
   typedef enum int {
      GEN_BRANCH,
      GEN_MULTIPLY,
      GEN_SWI,
      GEN_DP_REG,
      GEN_DP_IMM,
      GEN_SINGLE,
      GEN_BLOCK,
      GEN_UNKNOWN,
      GEN_NOISE
   } word_kind_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // fetch_address[31:0], instruction_word[63:32]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // class, cond, operation, modifier, dest, base, second,
                                   // shift reg, form, shift type, value, count (low bit up)

   logic [63:0]       fetch_queue[$];    // words waiting to be offered
   decode_fields_type decoded_queue[$];  // decodes of accepted words, oldest first
   int                accepted_count = 0;
   int                error_count    = 0;
   int                cycle_count    = 0;
   int                hold_left      = 0;
   logic              hold_done      = 1'b0;
   logic              steady;

   instruction_class_field_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   assign steady = (accepted_count >= STEADY_FROM) && (accepted_count < STEADY_TO);

   // register operand with optional shift, shared by data processing and single transfer
   function automatic decode_fields_type add_reg_operand(input decode_fields_type d,
                                                         input logic [31:0] w);
      decode_fields_type r;
      r = d;
      r.second = w[3:0];
      // bits 11..4 all zero means a plain register, nothing else reported
      if ((w & icfd_pkg::SHIFT_MASK) != 32'd0) begin
         r.stype = w[6:5];
         if (w[4]) begin
            r.form  = icfd_pkg::FORM_REG_SHIFT;
            r.shreg = w[11:8];
         end else begin
            r.form  = icfd_pkg::FORM_IMM_SHIFT;
            r.value = {27'd0, w[11:7]};
         end
      end
      return r;
   endfunction

   // decode one word the way the block should, in class priority order
   function automatic decode_fields_type decode_word(input logic [31:0] addr,
                                                     input logic [31:0] w);
      decode_fields_type d;
      logic [2:0]        grp;
      logic [31:0]       offset;
      logic [63:0]       rotated;
      logic [4:0]        rot;
      d = '0;
      d.cond = w[31:28];
      grp = w[27:25];
      if (grp == icfd_pkg::GRP_BRANCH) begin
         d.iclass    = icfd_pkg::CLASS_BRANCH;
         d.operation = {3'd0, w[24]};
         offset      = {{8{w[23]}}, w[23:0]};
         d.value     = addr + icfd_pkg::PIPE_OFFSET + (offset << 2);
      end else if ((w & icfd_pkg::MUL_MASK) == icfd_pkg::MUL_MATCH) begin
         d.iclass    = icfd_pkg::CLASS_MULTIPLY;
         d.operation = {3'd0, w[21]};
         d.modifier  = {3'd0, w[20]};
         d.dest      = w[19:16];
         d.base      = w[15:12];
         d.second    = w[3:0];
         d.shreg     = w[11:8];
      end else if ((w & icfd_pkg::SWI_MASK) == icfd_pkg::SWI_MASK) begin
         d.iclass = icfd_pkg::CLASS_SWI;
         d.value  = {8'd0, w[23:0]};
      end else if (grp == icfd_pkg::GRP_DP_REG || grp == icfd_pkg::GRP_DP_IMM) begin
         d.iclass    = icfd_pkg::CLASS_DATA_PROC;
         d.operation = w[24:21];
         // psr mark: compare ops with the pc as destination field
         d.modifier  = {(w[24:23] == icfd_pkg::OPC_COMPARE_GRP)
                        && (w[15:12] == icfd_pkg::REG_PC), 2'b00, w[20]};
         d.dest      = w[15:12];
         d.base      = w[19:16];
         if (grp == icfd_pkg::GRP_DP_IMM) begin
            d.form  = icfd_pkg::FORM_IMMEDIATE;
            rot     = {w[11:8], 1'b0};
            rotated = {24'd0, w[7:0], 24'd0, w[7:0]} >> rot;
            d.value = rotated[31:0];
         end else begin
            d = add_reg_operand(d, w);
         end
      end else if (grp == icfd_pkg::GRP_SINGLE_IMM || grp == icfd_pkg::GRP_SINGLE_REG) begin
         d.iclass    = icfd_pkg::CLASS_SINGLE;
         d.operation = {3'd0, w[20]};
         d.modifier  = {1'b0, w[21], w[22], 1'b0};
         d.dest      = w[15:12];
         d.base      = w[19:16];
         // the 12-bit offset form stays undecoded
         if (grp == icfd_pkg::GRP_SINGLE_REG) begin
            d = add_reg_operand(d, w);
         end
      end else if (grp == icfd_pkg::GRP_BLOCK) begin
         d.iclass    = icfd_pkg::CLASS_BLOCK;
         d.operation = {1'b0, w[20], w[24:23]};
         d.modifier  = {w[22], w[21], 2'b00};
         d.base      = w[19:16];
         d.value     = {16'd0, w[15:0]};
         for (int i = 0; i < 16; i++) begin
            d.count = d.count + {4'd0, w[i]};
         end
      end else begin
         d.iclass = icfd_pkg::CLASS_UNKNOWN;
      end
      return d;
   endfunction

   // random word of the given kind, random content in every free bit
   function automatic logic [31:0] make_word(input word_kind_type kind);
      logic [31:0] w;
      w = $urandom();
      case (kind)
         GEN_BRANCH: begin
            w[27:25] = icfd_pkg::GRP_BRANCH;
         end
         GEN_MULTIPLY: begin
            w[27:22] = 6'd0;
            w[7:4]   = 4'b1001;
         end
         GEN_SWI: begin
            w[27:24] = 4'hf;
         end
         GEN_DP_REG, GEN_DP_IMM: begin
            w[27:25] = (kind == GEN_DP_REG) ? icfd_pkg::GRP_DP_REG : icfd_pkg::GRP_DP_IMM;
            if ($urandom_range(0, 3) == 0) begin
               w[11:4] = 8'd0;
            end
            // steer some words into the compare group with the pc as destination
            if ($urandom_range(0, 3) == 0) begin
               w[24:23] = icfd_pkg::OPC_COMPARE_GRP;
               w[15:12] = icfd_pkg::REG_PC;
            end
         end
         GEN_SINGLE: begin
            w[27:26] = 2'b01;
            if ($urandom_range(0, 3) == 0) begin
               w[11:4] = 8'd0;
            end
         end
         GEN_BLOCK: begin
            w[27:25] = icfd_pkg::GRP_BLOCK;
            case ($urandom_range(0, 7))
               0: w[15:0] = 16'h0000;
               1: w[15:0] = 16'hffff;
               default: ;
            endcase
         end
         GEN_UNKNOWN: begin
            w[27:25] = 3'b110 | 3'($urandom_range(0, 1));
            w[24]    = 1'b0;
         end
         default: ;
      endcase
      return w;
   endfunction

   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= REPORT_MAX) begin
            $display("mismatch in %s: expected %h, got %h", name, want, got);
         end
      end
   endtask

   // sender: offers the next queued word once the previous one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (fetch_queue.size() > 0 && (steady || $urandom_range(0, 99) >= 10)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= fetch_queue.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, one long hold-off while the sender keeps going
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!hold_done && accepted_count >= HOLD_START) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= steady || ($urandom_range(0, 99) >= 10);
      end
   end

   // monitor: decode each accepted word, check each result transaction in order
   always @(posedge clock) begin : monitor
      decode_fields_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            decoded_queue.push_back(decode_word(req_tdata[31:0], req_tdata[63:32]));
            accepted_count <= accepted_count + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_queue.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_MAX) begin
                  $display("result transaction with nothing outstanding: %h", rsp_tdata);
               end
            end else begin
               want = decoded_queue.pop_front();
               report_field("instr_class",    32'(want.iclass),  32'(rsp_tdata[2:0]));
               report_field("cond_code",      32'(want.cond),     32'(rsp_tdata[6:3]));
               report_field("operation",      32'(want.operation), 32'(rsp_tdata[10:7]));
               report_field("modifier_flags", 32'(want.modifier), 32'(rsp_tdata[14:11]));
               report_field("reg_dest",       32'(want.dest),     32'(rsp_tdata[18:15]));
               report_field("reg_base",       32'(want.base),     32'(rsp_tdata[22:19]));
               report_field("reg_second",     32'(want.second),   32'(rsp_tdata[26:23]));
               report_field("reg_shift",      32'(want.shreg),    32'(rsp_tdata[30:27]));
               report_field("operand_form",   32'(want.form),     32'(rsp_tdata[32:31]));
               report_field("shift_type",     32'(want.stype),    32'(rsp_tdata[34:33]));
               report_field("value_out",      want.value,         rsp_tdata[66:35]);
               report_field("register_count", 32'(want.count),    32'(rsp_tdata[71:67]));
            end
         end
      end
   end

   // watchdog on a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      logic [31:0]   addr;
      word_kind_type kind;

      // directed words: {instruction_word, fetch_address}
      fetch_queue.push_back({32'hea000000, 32'h00001000});  // branch, zero offset
      fetch_queue.push_back({32'heaffffff, 32'h00000000});  // branch, offset -1
      fetch_queue.push_back({32'h0a800000, 32'h00000000});  // most negative offset, wraps
      fetch_queue.push_back({32'heb000000, 32'hfffffff8});  // link, target wraps to zero
      fetch_queue.push_back({32'he0010392, 32'h00000000});  // plain multiply
      fetch_queue.push_back({32'hf03fff9f, 32'hffffffff});  // accumulate, set flags, all ones
      fetch_queue.push_back({32'hef123456, 32'h00000000});  // swi comment
      fetch_queue.push_back({32'hffffffff, 32'hffffffff});  // swi, every bit set
      fetch_queue.push_back({32'h00000000, 32'hffffffff});  // dp, all zero, no shift
      fetch_queue.push_back({32'he1a00f81, 32'h00000000});  // lsl by 31
      fetch_queue.push_back({32'he1a000c1, 32'h00000000});  // asr by 1
      fetch_queue.push_back({32'he0912371, 32'h00000000});  // register shift ror
      fetch_queue.push_back({32'he1000090, 32'h00000000});  // near-multiply, decodes as dp
      fetch_queue.push_back({32'he3a000ff, 32'h00000000});  // immediate, no rotation
      fetch_queue.push_back({32'he3a00fff, 32'h00000000});  // immediate, largest rotation
      fetch_queue.push_back({32'he3a001ff, 32'h00000000});  // immediate, rotation by two
      fetch_queue.push_back({32'he350f000, 32'h00000000});  // compare with pc field: psr mark
      fetch_queue.push_back({32'he12ff001, 32'h00000000});  // teq with pc field, no set flags
      fetch_queue.push_back({32'he1a0f00e, 32'h00000000});  // mov to pc: no mark
      fetch_queue.push_back({32'he5e12004, 32'h00000000});  // single, 12-bit offset, byte+wb
      fetch_queue.push_back({32'he7912103, 32'h00000000});  // single, scaled register
      fetch_queue.push_back({32'he7912003, 32'h00000000});  // single, plain register
      fetch_queue.push_back({32'he8b00000, 32'h00000000});  // block, empty list
      fetch_queue.push_back({32'he96dffff, 32'h00000000});  // block, full list, user mark
      fetch_queue.push_back({32'hec000000, 32'h00000000});  // unknown group
      fetch_queue.push_back({32'hfe000010, 32'h00000000});  // unknown, top group, bit 24 low

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         kind = word_kind_type'($urandom_range(0, int'(GEN_NOISE)));
         addr = ($urandom_range(0, 15) == 0) ? (32'hffffff00 | $urandom_range(0, 255))
                                             : $urandom();
         fetch_queue.push_back({make_word(kind), addr});
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // sample between edges so nothing races the driver
      do begin
         @(negedge clock);
      end while (fetch_queue.size() != 0 || req_tvalid || decoded_queue.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (error_count == 0 && decoded_queue.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/icfd_pkg.sv
hdl/icfd_classify.sv
hdl/icfd_extract.sv
hdl/icfd_format.sv
hdl/instruction_class_field_decoder.sv
tb/sv/instruction_class_field_decoder_tb.sv
